// ===== sv/ppf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the printer packet framer.
// No dependencies.
package ppf_pkg;

  typedef enum logic [1:0] {
    OP_HEADER  = 2'd0,
    OP_BODY    = 2'd1,
    OP_TRAILER = 2'd2,
    OP_REPLY   = 2'd3
  } opcode_e;

  localparam logic [7:0] SYNC_FIRST  = 8'h88;
  localparam logic [7:0] SYNC_SECOND = 8'h33;
  localparam logic [7:0] ACK_A       = 8'h80;
  localparam logic [7:0] ACK_B       = 8'h81;

  // beat index of the last result of each item kind
  localparam logic [2:0] HEADER_LAST  = 3'd5;
  localparam logic [2:0] TRAILER_LAST = 3'd3;
  localparam logic [2:0] SINGLE_LAST  = 3'd0;

endpackage

// ===== sv/printer_packet_framer_unit.sv =====
`timescale 1ns / 1ps
// Printer packet framer: turns header/body/trailer/reply items into a byte stream.
// Depends on ppf_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one item per accepted edge:
//   header, body byte, trailer or reply check. Output channel
//   (out_valid_o / out_stall_i) delivers one result per accepted edge.
//   A header expands to six results (sync 0x88 0x33, code, flag, length
//   low/high), a trailer to four (checksum low/high, two 0x00 polls), body
//   and reply items to one. last_of_run_o marks the final result of an item.
// The item register, then the output register, lie between an accepted item
//   and its first result on the outputs.
// Throughput: while the receiver does not stall, one result per cycle, set by the
//   single output register; body and reply items then flow at one item per cycle,
//   and a header or trailer holds the input until its last result is handed over.
// The checksum register is updated when an item is accepted; a trailer
//   snapshots it at that moment, so items in flight never disturb it.
// Reset clears the checksum, the item valid flag and beat index and the output valid flag; data fields are not reset.
// When the receiver stalls, the output holds its result and the input stalls
//   once the item register cannot hand over its next result.
module printer_packet_framer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [3:0]  command_code_i,
  input  logic        compressed_i,
  input  logic [15:0] body_length_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  reply_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  tx_byte_o,
  output logic        tx_valid_o,
  output logic        last_of_run_o,
  output logic        ack_ok_o
);
  import ppf_pkg::*;

  // checksum state
  logic [15:0] sum_q, sum_d;

  // item register: the item being expanded into results
  logic        a_valid_q, a_valid_d;
  opcode_e     a_op_q;
  logic [2:0]  a_beat_q, a_beat_d;
  logic [2:0]  a_last_q;
  logic [3:0]  a_code_q;
  logic        a_comp_q;
  logic [15:0] a_word_q;   // body length, sum snapshot, or data byte
  logic        a_ack_q;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [7:0]  tx_byte_q;
  logic        tx_valid_q, last_q, ack_q;

  logic        in_accept;
  logic        out_free;
  logic        a_advance;
  logic        a_done;
  opcode_e     in_op;
  logic [9:0]  hdr_sum;
  logic [7:0]  beat_byte;
  logic [2:0]  in_last;

  assign in_op     = opcode_e'(opcode_i);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign a_advance = a_valid_q && out_free;
  assign a_done    = a_advance && (a_beat_q == a_last_q);
  assign in_stall_o = a_valid_q && !a_done;
  assign in_accept = in_valid_i && !in_stall_o;

  assign hdr_sum = {6'd0, command_code_i} + {9'd0, compressed_i}
                 + {2'd0, body_length_i[7:0]} + {2'd0, body_length_i[15:8]};

  always_comb begin
    unique case (in_op)
      OP_HEADER:  in_last = HEADER_LAST;
      OP_TRAILER: in_last = TRAILER_LAST;
      default:    in_last = SINGLE_LAST;
    endcase
  end

  // checksum update at acceptance
  always_comb begin
    sum_d = sum_q;
    if (in_accept) begin
      unique case (in_op)
        OP_HEADER: sum_d = {6'd0, hdr_sum};
        OP_BODY:   sum_d = sum_q + {8'd0, data_byte_i};
        default:   sum_d = sum_q;
      endcase
    end
  end

  // item register control
  always_comb begin
    a_valid_d = a_valid_q;
    a_beat_d  = a_beat_q;
    if (a_advance) begin
      a_beat_d = a_beat_q + 3'd1;
    end
    if (a_done) begin
      a_valid_d = 1'b0;
    end
    if (in_accept) begin
      a_valid_d = 1'b1;
      a_beat_d  = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= 16'd0;
      a_valid_q <= 1'b0;
      a_beat_q  <= 3'd0;
    end else begin
      sum_q     <= sum_d;
      a_valid_q <= a_valid_d;
      a_beat_q  <= a_beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_op_q   <= in_op;
      a_last_q <= in_last;
      a_code_q <= command_code_i;
      a_comp_q <= compressed_i;
      a_ack_q  <= (reply_byte_i == ACK_A) || (reply_byte_i == ACK_B);
      case (in_op)
        OP_HEADER:  a_word_q <= body_length_i;
        OP_BODY:    a_word_q <= {8'd0, data_byte_i};
        default:    a_word_q <= sum_q;
      endcase
    end
  end

  // byte for the current beat
  always_comb begin
    beat_byte = 8'd0;
    case (a_op_q)
      OP_HEADER: begin
        case (a_beat_q)
          3'd0:    beat_byte = SYNC_FIRST;
          3'd1:    beat_byte = SYNC_SECOND;
          3'd2:    beat_byte = {4'd0, a_code_q};
          3'd3:    beat_byte = {7'd0, a_comp_q};
          3'd4:    beat_byte = a_word_q[7:0];
          default: beat_byte = a_word_q[15:8];
        endcase
      end
      OP_BODY: beat_byte = a_word_q[7:0];
      OP_TRAILER: begin
        case (a_beat_q)
          3'd0:    beat_byte = a_word_q[7:0];
          3'd1:    beat_byte = a_word_q[15:8];
          default: beat_byte = 8'd0;
        endcase
      end
      default: beat_byte = 8'd0;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = a_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_advance) begin
      tx_byte_q  <= beat_byte;
      tx_valid_q <= (a_op_q != OP_REPLY);
      last_q     <= (a_beat_q == a_last_q);
      ack_q      <= (a_op_q == OP_REPLY) && a_ack_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tx_byte_o     = tx_byte_q;
  assign tx_valid_o    = tx_valid_q;
  assign last_of_run_o = last_q;
  assign ack_ok_o      = ack_q;

endmodule

// ===== sv/ppf_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for printer_packet_framer_unit, bound to the top level.
// Depends on the top level's port list only.
module ppf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  tx_byte_o,
  input logic        tx_valid_o,
  input logic        last_of_run_o,
  input logic        ack_ok_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tx_byte_o)
      && $stable(last_of_run_o))
    else $error("stalled result changed");

  // a result with no byte carries a zero byte and ends its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tx_valid_o |-> tx_byte_o == 8'd0 && last_of_run_o)
    else $error("reply result malformed");

  // acknowledge only on a reply result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ack_ok_o |-> !tx_valid_o)
    else $error("ack on a byte result");

  // only the final result of an item may lack a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> tx_valid_o)
    else $error("byte missing inside an item");

endmodule

bind printer_packet_framer_unit ppf_checker u_ppf_checker (.*);
